### design/source_tokenizer_defines.svh
// assertion helpers for the checker file stok_checker.sv
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("source_tokenizer check failed");

// next-cycle implication, disabled in reset
`define ST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("source_tokenizer check failed");

`endif

### design/stok_pkg.sv
`timescale 1ns / 1ps
package stok_pkg;

    localparam int NKW = 14;
    localparam logic [16:0] LEN_MAX = 17'h1FFFF;
    localparam logic [NKW-1:0] KW_ALL = '1;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_STR     = 4'd1;
    localparam logic [3:0] M_SIGN    = 4'd2;
    localparam logic [3:0] M_INT     = 4'd3;
    localparam logic [3:0] M_FRAC    = 4'd4;
    localparam logic [3:0] M_WORD    = 4'd5;
    localparam logic [3:0] M_SPACE   = 4'd6;
    localparam logic [3:0] M_SLASH   = 4'd7;
    localparam logic [3:0] M_COMMENT = 4'd8;
    localparam logic [3:0] M_OP      = 4'd9;

    localparam logic [5:0] K_STRING  = 6'd0;
    localparam logic [5:0] K_INT     = 6'd1;
    localparam logic [5:0] K_FLOAT   = 6'd2;
    localparam logic [5:0] K_KW0     = 6'd3;
    localparam logic [5:0] K_IDENT   = 6'd17;
    localparam logic [5:0] K_SPACE   = 6'd18;
    localparam logic [5:0] K_COMMENT = 6'd19;
    localparam logic [5:0] K_ARROW   = 6'd20;
    localparam logic [5:0] K_SHL     = 6'd21;
    localparam logic [5:0] K_SHR     = 6'd22;
    localparam logic [5:0] K_LAND    = 6'd23;
    localparam logic [5:0] K_LOR     = 6'd24;
    localparam logic [5:0] K_EQ      = 6'd25;
    localparam logic [5:0] K_NE      = 6'd26;
    localparam logic [5:0] K_LE      = 6'd27;
    localparam logic [5:0] K_GE      = 6'd28;
    localparam logic [5:0] K_SCOPE   = 6'd29;
    localparam logic [5:0] K_LBRACE  = 6'd30;
    localparam logic [5:0] K_RBRACE  = 6'd31;
    localparam logic [5:0] K_LBRACK  = 6'd32;
    localparam logic [5:0] K_RBRACK  = 6'd33;
    localparam logic [5:0] K_LPAREN  = 6'd34;
    localparam logic [5:0] K_RPAREN  = 6'd35;
    localparam logic [5:0] K_ASSIGN  = 6'd36;
    localparam logic [5:0] K_PLUS    = 6'd37;
    localparam logic [5:0] K_MINUS   = 6'd38;
    localparam logic [5:0] K_STAR    = 6'd39;
    localparam logic [5:0] K_DIV     = 6'd40;
    localparam logic [5:0] K_MODOP   = 6'd41;
    localparam logic [5:0] K_AMP     = 6'd42;
    localparam logic [5:0] K_BAR     = 6'd43;
    localparam logic [5:0] K_CARET   = 6'd44;
    localparam logic [5:0] K_TILDE   = 6'd45;
    localparam logic [5:0] K_BANG    = 6'd46;
    localparam logic [5:0] K_LT      = 6'd47;
    localparam logic [5:0] K_GT      = 6'd48;
    localparam logic [5:0] K_AT      = 6'd49;
    localparam logic [5:0] K_DOT     = 6'd50;
    localparam logic [5:0] K_SEMI    = 6'd51;
    localparam logic [5:0] K_ERROR   = 6'd52;
    localparam logic [5:0] K_UNTERM  = 6'd53;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef struct packed {
        logic [3:0]     mode;
        logic [16:0]    len;
        logic [7:0]     hbyte;
        logic           hvalid;
        logic           esc;
        logic [NKW-1:0] mask;
    } t_scan_state;

    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] start;
        logic [16:0] len;
    } t_token;

    // keyword text, padded with spaces to six characters
    function automatic logic [47:0] kw_word(input logic [3:0] i);
        case (i)
            4'd0:    kw_word = "mod   ";
            4'd1:    kw_word = "use   ";
            4'd2:    kw_word = "as    ";
            4'd3:    kw_word = "pub   ";
            4'd4:    kw_word = "fun   ";
            4'd5:    kw_word = "return";
            4'd6:    kw_word = "ext   ";
            4'd7:    kw_word = "record";
            4'd8:    kw_word = "if    ";
            4'd9:    kw_word = "else  ";
            4'd10:   kw_word = "while ";
            4'd11:   kw_word = "var   ";
            4'd12:   kw_word = "unit  ";
            4'd13:   kw_word = "sizeof";
            default: kw_word = "      ";
        endcase
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] i);
        case (i)
            4'd2, 4'd8:          kw_len = 3'd2;
            4'd9, 4'd12:         kw_len = 3'd4;
            4'd10:               kw_len = 3'd5;
            4'd5, 4'd7, 4'd13:   kw_len = 3'd6;
            default:             kw_len = 3'd3;
        endcase
    endfunction

    // drop keywords that have no character at idx or whose character there differs from c
    function automatic logic [NKW-1:0] kw_keep(input logic [NKW-1:0] mask,
                                               input logic [7:0] c,
                                               input logic [16:0] idx);
        logic [NKW-1:0] m;
        logic [47:0]    w;
        logic [7:0]     ch;
        m = mask;
        for (int i = 0; i < NKW; i++) begin
            w  = kw_word(4'(i));
            ch = 8'(w >> (6'd40 - {idx[2:0], 3'b000}));
            if (!(idx < 17'(kw_len(4'(i))) && ch == c))
                m[i] = 1'b0;
        end
        return m;
    endfunction

    function automatic logic [5:0] word_kind(input logic [NKW-1:0] mask,
                                             input logic [16:0] len);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = NKW - 1; i >= 0; i--) begin
            if (mask[i] && len == 17'(kw_len(4'(i))))
                k = K_KW0 + 6'(i);
        end
        return k;
    endfunction

endpackage

### design/stok_step.sv
`timescale 1ns / 1ps
module stok_step
    import stok_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  t_scan_state            i_state,
    input  logic [OFFSET_BITS-1:0] i_pos,
    input  logic [OFFSET_BITS-1:0] i_begin,
    input  logic [7:0]             i_byte,
    input  logic                   i_final,
    input  logic                   i_drop,
    output t_scan_state            o_state,
    output logic [OFFSET_BITS-1:0] o_pos,
    output logic [OFFSET_BITS-1:0] o_begin,
    output t_token                 o_tok [2],
    output logic [1:0]             o_count
);

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_dig(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_SP;
    endfunction

    function automatic logic [16:0] grow(input logic [16:0] len);
        return (len < LEN_MAX) ? len + 17'd1 : len;
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
        logic [5:0] k;
        k = K_ERROR;
        if (h == CH_LT && c == CH_LT)      k = K_SHL;
        else if (h == CH_GT && c == CH_GT) k = K_SHR;
        else if (h == CH_AMP && c == CH_AMP) k = K_LAND;
        else if (h == CH_BAR && c == CH_BAR) k = K_LOR;
        else if (h == CH_EQ && c == CH_EQ) k = K_EQ;
        else if (h == CH_BANG && c == CH_EQ) k = K_NE;
        else if (h == CH_LT && c == CH_EQ) k = K_LE;
        else if (h == CH_GT && c == CH_EQ) k = K_GE;
        else if (h == CH_COLON && c == CH_COLON) k = K_SCOPE;
        return k;
    endfunction

    function automatic logic [5:0] op_single(input logic [7:0] h);
        case (h)
            CH_LT:   op_single = K_LT;
            CH_GT:   op_single = K_GT;
            CH_AMP:  op_single = K_AMP;
            CH_BAR:  op_single = K_BAR;
            CH_EQ:   op_single = K_ASSIGN;
            CH_BANG: op_single = K_BANG;
            default: op_single = K_ERROR;
        endcase
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        case (c)
            CH_LBRC:  single_kind = K_LBRACE;
            CH_RBRC:  single_kind = K_RBRACE;
            CH_LBRK:  single_kind = K_LBRACK;
            CH_RBRK:  single_kind = K_RBRACK;
            CH_LPAR:  single_kind = K_LPAREN;
            CH_RPAR:  single_kind = K_RPAREN;
            CH_STAR:  single_kind = K_STAR;
            CH_PCT:   single_kind = K_MODOP;
            CH_CARET: single_kind = K_CARET;
            CH_TILDE: single_kind = K_TILDE;
            CH_AT:    single_kind = K_AT;
            CH_DOT:   single_kind = K_DOT;
            CH_SEMI:  single_kind = K_SEMI;
            default:  single_kind = K_ERROR;
        endcase
    endfunction

    function automatic logic [5:0] flush_kind(input t_scan_state s);
        case (s.mode)
            M_STR:     flush_kind = K_UNTERM;
            M_SIGN:    flush_kind = (s.hbyte == CH_PLUS) ? K_PLUS : K_MINUS;
            M_INT:     flush_kind = K_INT;
            M_FRAC:    flush_kind = K_FLOAT;
            M_WORD:    flush_kind = word_kind(s.mask, s.len);
            M_SPACE:   flush_kind = K_SPACE;
            M_SLASH:   flush_kind = K_DIV;
            M_COMMENT: flush_kind = K_COMMENT;
            M_OP:      flush_kind = op_single(s.hbyte);
            default:   flush_kind = K_ERROR;
        endcase
    endfunction

    function automatic logic keep(input logic [5:0] k, input logic drop);
        return !(drop && (k == K_SPACE || k == K_COMMENT));
    endfunction

    t_scan_state            s;
    logic [OFFSET_BITS-1:0] bg;
    logic [31:0]            bg_wide;
    logic [2:0]             ev;
    t_token                 et [3];
    logic                   do_flush;
    logic                   do_start;
    logic [7:0]             c;

    always_comb begin
        c        = i_byte;
        s        = i_state;
        bg       = i_begin;
        ev       = '0;
        et[0]    = '0;
        et[1]    = '0;
        et[2]    = '0;
        bg_wide  = '0;
        do_flush = 1'b0;
        do_start = 1'b0;

        // extend the open token with c, or close it
        case (s.mode)
            M_STR: begin
                s.len = grow(s.len);
                if (c == CH_DQ && !s.esc) begin
                    bg_wide = 32'(bg);
                    ev[0]   = keep(K_STRING, i_drop);
                    et[0]   = '{K_STRING, bg_wide[15:0], s.len};
                    s.mode  = M_IDLE;
                end else begin
                    s.esc = !s.esc && c == CH_BSL;
                end
            end
            M_INT: begin
                if (is_dig(c)) s.len = grow(s.len);
                else if (c == CH_DOT) begin
                    s.len  = grow(s.len);
                    s.mode = M_FRAC;
                end else do_flush = 1'b1;
            end
            M_FRAC: begin
                if (is_dig(c)) s.len = grow(s.len);
                else do_flush = 1'b1;
            end
            M_SIGN: begin
                if (is_dig(c)) begin
                    s.len    = grow(s.len);
                    s.hvalid = 1'b0;
                    s.mode   = M_INT;
                end else if (s.hbyte == CH_MINUS && c == CH_GT) begin
                    s.len    = grow(s.len);
                    bg_wide  = 32'(bg);
                    ev[0]    = 1'b1;
                    et[0]    = '{K_ARROW, bg_wide[15:0], s.len};
                    s.mode   = M_IDLE;
                    s.hvalid = 1'b0;
                end else do_flush = 1'b1;
            end
            M_WORD: begin
                if (is_alnum(c)) begin
                    s.mask = kw_keep(s.mask, c, s.len);
                    s.len  = grow(s.len);
                end else do_flush = 1'b1;
            end
            M_SPACE: begin
                if (is_ws(c)) s.len = grow(s.len);
                else do_flush = 1'b1;
            end
            M_SLASH: begin
                if (c == CH_SLASH) begin
                    s.len    = grow(s.len);
                    s.hvalid = 1'b0;
                    s.mode   = M_COMMENT;
                end else do_flush = 1'b1;
            end
            M_COMMENT: begin
                if (c != CH_LF && c != CH_CR) s.len = grow(s.len);
                else do_flush = 1'b1;
            end
            M_OP: begin
                if (pair_kind(s.hbyte, c) != K_ERROR) begin
                    s.len    = grow(s.len);
                    bg_wide  = 32'(bg);
                    ev[0]    = 1'b1;
                    et[0]    = '{pair_kind(s.hbyte, c), bg_wide[15:0], s.len};
                    s.mode   = M_IDLE;
                    s.hvalid = 1'b0;
                end else do_flush = 1'b1;
            end
            default: do_start = 1'b1;
        endcase

        if (do_flush) begin
            bg_wide  = 32'(bg);
            ev[0]    = keep(flush_kind(s), i_drop);
            et[0]    = '{flush_kind(s), bg_wide[15:0], s.len};
            do_start = 1'b1;
        end

        // c opens a new token
        if (do_start) begin
            bg       = i_pos;
            s.len    = 17'd1;
            s.mask   = KW_ALL;
            s.esc    = 1'b0;
            s.hvalid = 1'b0;
            s.hbyte  = '0;
            s.mode   = M_IDLE;
            if (c == CH_DQ) s.mode = M_STR;
            else if (is_dig(c)) s.mode = M_INT;
            else if (c == CH_PLUS || c == CH_MINUS) begin
                s.hbyte  = c;
                s.hvalid = 1'b1;
                s.mode   = M_SIGN;
            end else if (is_alnum(c)) begin
                s.mask = kw_keep(KW_ALL, c, 17'd0);
                s.mode = M_WORD;
            end else if (is_ws(c)) s.mode = M_SPACE;
            else if (c == CH_SLASH) begin
                s.hbyte  = c;
                s.hvalid = 1'b1;
                s.mode   = M_SLASH;
            end else if (c == CH_LT || c == CH_GT || c == CH_AMP || c == CH_BAR
                         || c == CH_EQ || c == CH_BANG || c == CH_COLON) begin
                s.hbyte  = c;
                s.hvalid = 1'b1;
                s.mode   = M_OP;
            end else begin
                bg_wide = 32'(bg);
                ev[1]   = 1'b1;
                et[1]   = '{single_kind(c), bg_wide[15:0], s.len};
            end
        end

        o_pos = i_pos + {{(OFFSET_BITS-1){1'b0}}, 1'b1};

        // end of source: report what is open and start over
        if (i_final) begin
            if (s.mode != M_IDLE) begin
                bg_wide = 32'(bg);
                ev[2]   = keep(flush_kind(s), i_drop);
                et[2]   = '{flush_kind(s), bg_wide[15:0], s.len};
            end
            s.mode   = M_IDLE;
            s.len    = '0;
            s.hbyte  = '0;
            s.hvalid = 1'b0;
            s.esc    = 1'b0;
            s.mask   = KW_ALL;
            bg       = '0;
            o_pos    = '0;
        end

        o_state = s;
        o_begin = bg;
    end

    // at most two of the three candidates are ever live
    always_comb begin
        o_tok[0] = ev[0] ? et[0] : (ev[1] ? et[1] : et[2]);
        o_tok[1] = (ev[0] && ev[1]) ? et[1] : et[2];
        o_count  = 2'(ev[0]) + 2'(ev[1]) + 2'(ev[2]);
    end

endmodule

### design/source_tokenizer.sv
`timescale 1ns / 1ps
// Streaming lexer: one source byte per item in, tokens out as kind, start offset and length.
// Bytes are taken one per cycle unless the output stalls; an item that yields two tokens (one
// ending plus a single-character token, or a token closed by the final byte) holds the input
// while the second token drains from the two-entry result register. A token that its own byte
// closes (quote, arrow, two-character operator, single character) is reported on that byte,
// any other on the byte after it ends or on the final byte of the source, after which offsets
// restart at zero. o_m_tuser[0] marks the last token of an item, o_m_tuser[1] the last token
// of the source. i_cfg_wr_data set to 1 drops whitespace and comment tokens (reset value 1).
module source_tokenizer
    import stok_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // source_byte[7:0]
    input  logic [0:0]  i_s_tuser,   // final_byte[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // token_kind[5:0], token_start[21:6], token_length[38:22]
    output logic [1:0]  o_m_tuser    // run_last[0], source_done[1]
);

    t_scan_state            r_st, n_st;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_begin, n_begin;
    logic                   r_drop;
    t_token                 r_tok [2];
    t_token                 n_tok [2];
    logic [1:0]             n_count;
    logic [1:0]             r_cnt;
    logic                   r_idx;
    logic                   r_fin;
    logic                   in_fire, out_fire;
    t_token                 head;

    stok_step #(.OFFSET_BITS(OFFSET_BITS)) u_step (
        .i_state (r_st),
        .i_pos   (r_pos),
        .i_begin (r_begin),
        .i_byte  (i_s_tdata),
        .i_final (i_s_tuser[0]),
        .i_drop  (r_drop),
        .o_state (n_st),
        .o_pos   (n_pos),
        .o_begin (n_begin),
        .o_tok   (n_tok),
        .o_count (n_count)
    );

    assign o_s_tready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_m_tready);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign out_fire   = o_m_tvalid && i_m_tready;

    assign head       = r_tok[r_idx];
    assign o_m_tvalid = r_cnt != 2'd0;
    assign o_m_tdata  = {1'b0, head.len, head.start, head.kind};
    assign o_m_tuser  = {r_fin && r_cnt == 2'd1, r_cnt == 2'd1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= '{M_IDLE, 17'd0, 8'd0, 1'b0, 1'b0, KW_ALL};
            r_pos   <= '0;
            r_begin <= '0;
            r_drop  <= 1'b1;
            r_cnt   <= 2'd0;
            r_idx   <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_drop <= i_cfg_wr_data;
            if (in_fire) begin
                r_st    <= n_st;
                r_pos   <= n_pos;
                r_begin <= n_begin;
                r_cnt   <= n_count;
                r_idx   <= 1'b0;
                r_fin   <= i_s_tuser[0];
            end else if (out_fire) begin
                r_cnt <= r_cnt - 2'd1;
                r_idx <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_tok[0] <= n_tok[0];
            r_tok[1] <= n_tok[1];
        end
    end

endmodule

### design/stok_checker.sv
`timescale 1ns / 1ps
`include "source_tokenizer_defines.svh"
module stok_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [1:0]  o_m_tuser
);

    // a stalled item stays offered
    `ST_ASSERT_NXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid)

    // no new byte while a token is stuck at the output
    `ST_ASSERT_IMP(a_in_blocked, o_m_tvalid && !i_m_tready, !o_s_tready)

    // tokens of one item leave back to back
    `ST_ASSERT_NXT(a_run_cont, o_m_tvalid && i_m_tready && !o_m_tuser[0], o_m_tvalid)

endmodule

bind source_tokenizer stok_checker u_stok_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tuser  (o_m_tuser)
);
